// File: rtl/assert_macros.svh
// Assertion macros for the RTL of the tagged interval map.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset disabling it.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Property that must hold at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/tim_pkg.sv
// Package of the tagged interval map: word types, codes and defaults.
// Depends on nothing; used by tagged_interval_map_core, the checker and the testbench.
package tim_pkg;

  localparam int unsigned MaxSplitsDef = 64;
  localparam int unsigned TagCountDef  = 8;

  localparam int unsigned AddrW = 64;
  localparam int unsigned TagW  = 3;
  localparam int unsigned IdxW  = 6;

  // Command codes.
  localparam logic [1:0] CMD_SPLIT  = 2'd0;
  localparam logic [1:0] CMD_GET    = 2'd1;
  localparam logic [1:0] CMD_REGION = 2'd2;

  // Status codes.
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_NO_MORE  = 3'd1;
  localparam logic [2:0] STAT_ABSENT   = 3'd2;
  localparam logic [2:0] STAT_IDX_BIG  = 3'd3;
  localparam logic [2:0] STAT_RANGE    = 3'd4;
  localparam logic [2:0] STAT_FULL     = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RANGE_MIN   = 2'd0;
  localparam logic [1:0] CFG_RANGE_MAX   = 2'd1;
  localparam logic [1:0] CFG_INITIAL_TAG = 2'd2;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] length;
    logic [TagW-1:0]  tag_in;
    logic [IdxW-1:0]  iterate_index;
  } tim_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [AddrW-1:0] range_start;
    logic [AddrW-1:0] range_end;
    logic [TagW-1:0]  tag_out;
    logic [IdxW:0]    next_index;
  } tim_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_READ, ST_EVAL, ST_INS_S, ST_INS_E, ST_COMMIT, ST_FINISH
  } tim_state_e;

  typedef enum logic [2:0] {
    MD_GET, MD_REGION, MD_COUNT, MD_LOW, MD_HIGH
  } tim_mode_e;

endpackage

// File: rtl/tagged_interval_map_core.sv
// Top level of the tagged interval map: sequencer over a two-bank split table.
// Depends on tim_pkg and assert_macros.svh.
//
//  channel  direction  signals                          word
//  in       input      in_valid_i / in_stall_o          tim_in_t
//  out      output     out_valid_o / out_stall_i        tim_out_t
//  cfg      input      cfg_we_i, cfg_idx_i, cfg_data_i  64-bit data
//
// Every table visit is a read issue, then a compare, on the one table read
// port; a get or region query visits entries until it has its answer, a split
// makes a count pass and then a copy pass into the other bank. Reset and a
// write to any of the three configuration registers restore the single
// initial point without a clearing pass. A stalled result stays in the
// output register; the next word is taken while it waits.
`include "assert_macros.svh"

module tagged_interval_map_core
  import tim_pkg::*;
#(
  parameter int unsigned MAX_SPLITS = MaxSplitsDef,
  parameter int unsigned TAG_COUNT  = TagCountDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tim_in_t          in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output tim_out_t         out_word_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [AddrW-1:0] cfg_data_i
);

  localparam int unsigned IW = $clog2(MAX_SPLITS);
  localparam int unsigned CW = $clog2(MAX_SPLITS + 1);

  // Configuration registers.
  logic [AddrW-1:0] range_min_q, range_max_q;
  logic [TagW-1:0]  init_tag_q;

  // Table state.
  logic [AddrW-1:0] keys_mem [2*MAX_SPLITS];
  logic [TagW-1:0]  tags_mem [2*MAX_SPLITS];
  logic             bank_q, bank_d;
  logic [CW-1:0]    count_q, count_d;
  logic             fresh_q, fresh_d;

  // Sequencer state.
  tim_state_e       state_q, state_d;
  tim_mode_e        mode_q, mode_d;
  tim_in_t          req_q, req_d;
  logic [AddrW:0]   end_q, end_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    wp_q, wp_d;
  logic [CW-1:0]    seen_q, seen_d;
  logic             hit_q, hit_d;
  logic             add_end_q, add_end_d;
  logic             lo_all_q, lo_all_d;
  logic [TagW-1:0]  etag_q, etag_d;
  tim_out_t         res_q, res_d;
  tim_out_t         out_q, out_d;
  logic             out_valid_q, out_valid_d;

  // Table read data.
  logic [AddrW-1:0] rd_key_q;
  logic [TagW-1:0]  rd_tag_q;
  logic             rd_fresh_q;
  logic [AddrW-1:0] cur_key;
  logic [TagW-1:0]  cur_tag;

  // Table write port.
  logic             we;
  logic [IW-1:0]    waddr;
  logic [AddrW-1:0] wkey;
  logic [TagW-1:0]  wtag;

  logic             last;
  logic [CW:0]      need;

  assign cur_key = rd_fresh_q ? range_min_q : rd_key_q;
  assign cur_tag = rd_fresh_q ? init_tag_q : rd_tag_q;
  assign last    = (CW'(idx_q) + CW'(1)) == count_q;
  assign need    = {1'b0, seen_q} + (CW+1)'(1) + (CW+1)'(add_end_q);

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Table memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      keys_mem[{~bank_q, waddr}] <= wkey;
      tags_mem[{~bank_q, waddr}] <= wtag;
    end
    if (state_q == ST_READ) begin
      rd_key_q   <= keys_mem[{bank_q, idx_q}];
      rd_tag_q   <= tags_mem[{bank_q, idx_q}];
      rd_fresh_q <= fresh_q && (idx_q == '0);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_min_q <= '0;
      range_max_q <= '1;
      init_tag_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RANGE_MIN:   range_min_q <= cfg_data_i;
        CFG_RANGE_MAX:   range_max_q <= cfg_data_i;
        CFG_INITIAL_TAG: init_tag_q  <= cfg_data_i[TagW-1:0];
        default: ;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      bank_q      <= 1'b0;
      count_q     <= CW'(1);
      fresh_q     <= 1'b1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      bank_q      <= bank_d;
      if (cfg_we_i && (cfg_idx_i == CFG_RANGE_MIN || cfg_idx_i == CFG_RANGE_MAX ||
                       cfg_idx_i == CFG_INITIAL_TAG)) begin
        count_q <= CW'(1);
        fresh_q <= 1'b1;
      end else begin
        count_q <= count_d;
        fresh_q <= fresh_d;
      end
    end
  end

  // Payload registers of the sequencer.
  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    req_q     <= req_d;
    end_q     <= end_d;
    idx_q     <= idx_d;
    wp_q      <= wp_d;
    seen_q    <= seen_d;
    hit_q     <= hit_d;
    add_end_q <= add_end_d;
    lo_all_q  <= lo_all_d;
    etag_q    <= etag_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  // Sequencer: next state, table writes and result building.
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    req_d       = req_q;
    end_d       = end_q;
    idx_d       = idx_q;
    wp_d        = wp_q;
    seen_d      = seen_q;
    hit_d       = hit_q;
    add_end_d   = add_end_q;
    lo_all_d    = lo_all_q;
    etag_d      = etag_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    bank_d      = bank_q;
    count_d     = count_q;
    fresh_d     = fresh_q;
    we          = 1'b0;
    waddr       = wp_q[IW-1:0];
    wkey        = cur_key;
    wtag        = cur_tag;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_word_i;
          end_d   = {1'b0, in_word_i.addr} + {1'b0, in_word_i.length};
          res_d   = '0;
          idx_d   = '0;
          seen_d  = '0;
          hit_d   = 1'b0;
          state_d = ST_CHECK;
        end
      end

      // Range and argument checks decide whether the table is visited.
      ST_CHECK: begin
        state_d = ST_FINISH;
        case (req_q.cmd)
          CMD_GET: begin
            if (req_q.addr < range_min_q || req_q.addr >= range_max_q) begin
              res_d.status = STAT_RANGE;
            end else begin
              mode_d  = MD_GET;
              state_d = ST_READ;
            end
          end
          CMD_REGION: begin
            if (32'(req_q.iterate_index) >= 32'(MAX_SPLITS)) begin
              res_d.status = STAT_IDX_BIG;
            end else begin
              mode_d  = MD_REGION;
              state_d = ST_READ;
            end
          end
          CMD_SPLIT: begin
            if (32'(req_q.tag_in) >= 32'(TAG_COUNT) ||
                req_q.addr < range_min_q || req_q.addr >= range_max_q) begin
              res_d.status = STAT_RANGE;
            end else if (req_q.length == '0) begin
              res_d.status = STAT_OK;
            end else if (end_q[AddrW] || end_q[AddrW-1:0] > range_max_q) begin
              res_d.status = STAT_RANGE;
            end else begin
              add_end_d = end_q[AddrW-1:0] < range_max_q;
              mode_d    = MD_COUNT;
              state_d   = ST_READ;
            end
          end
          default: res_d.status = STAT_RANGE;
        endcase
      end

      ST_READ: state_d = ST_EVAL;

      // One table entry is examined per visit.
      ST_EVAL: begin
        state_d = ST_READ;
        idx_d   = idx_q + IW'(1);
        case (mode_q)
          MD_GET: begin
            if (cur_key <= req_q.addr) begin
              res_d.range_start = cur_key;
              res_d.tag_out     = cur_tag;
              if (last) begin
                res_d.range_end = range_max_q;
                state_d         = ST_FINISH;
              end
            end else begin
              res_d.range_end = cur_key;
              state_d         = ST_FINISH;
            end
          end
          MD_REGION: begin
            if (hit_q) begin
              res_d.range_end = cur_key;
              res_d.status    = STAT_OK;
              state_d         = ST_FINISH;
            end else if (cur_tag == req_q.tag_in &&
                         seen_q == CW'(req_q.iterate_index)) begin
              res_d.range_start = cur_key;
              res_d.tag_out     = cur_tag;
              res_d.next_index  = {1'b0, req_q.iterate_index} + 7'd1;
              hit_d             = 1'b1;
              if (last) begin
                res_d.range_end = range_max_q;
                res_d.status    = STAT_OK;
                state_d         = ST_FINISH;
              end
            end else begin
              if (cur_tag == req_q.tag_in) begin
                seen_d = seen_q + CW'(1);
              end
              if (last) begin
                res_d.status = (seen_d != '0) ? STAT_NO_MORE : STAT_ABSENT;
                state_d      = ST_FINISH;
              end
            end
          end
          MD_COUNT: begin
            // seen_q counts the points that survive the split here.
            if (cur_key <= end_q[AddrW-1:0]) begin
              etag_d = cur_tag;
            end
            if (cur_key < req_q.addr || cur_key > end_q[AddrW-1:0]) begin
              seen_d = seen_q + CW'(1);
            end
            if (last) begin
              mode_d = MD_LOW;
              idx_d  = '0;
              wp_d   = '0;
              state_d = ST_COMMIT;
            end
          end
          MD_LOW: begin
            if (cur_key < req_q.addr) begin
              we   = 1'b1;
              wp_d = wp_q + CW'(1);
              if (last) begin
                lo_all_d = 1'b1;
                state_d  = ST_INS_S;
              end
            end else begin
              idx_d    = idx_q;
              lo_all_d = 1'b0;
              state_d  = ST_INS_S;
            end
          end
          MD_HIGH: begin
            if (cur_key > end_q[AddrW-1:0]) begin
              we   = 1'b1;
              wp_d = wp_q + CW'(1);
            end
            if (last) begin
              state_d = ST_COMMIT;
            end
          end
          default: state_d = ST_FINISH;
        endcase
      end

      // The copy pass is past its low part once the start point is written.
      ST_INS_S: begin
        we      = 1'b1;
        wkey    = req_q.addr;
        wtag    = req_q.tag_in;
        wp_d    = wp_q + CW'(1);
        state_d = add_end_q ? ST_INS_E : (lo_all_q ? ST_COMMIT : ST_READ);
        mode_d  = MD_HIGH;
      end

      ST_INS_E: begin
        we      = 1'b1;
        wkey    = end_q[AddrW-1:0];
        wtag    = etag_q;
        wp_d    = wp_q + CW'(1);
        state_d = lo_all_q ? ST_COMMIT : ST_READ;
        mode_d  = MD_HIGH;
      end

      // Capacity check after the count pass, bank swap after the copy pass.
      ST_COMMIT: begin
        if (mode_q == MD_LOW) begin
          if (need > (CW+1)'(MAX_SPLITS)) begin
            res_d.status = STAT_FULL;
            state_d      = ST_FINISH;
          end else begin
            state_d = ST_READ;
          end
        end else begin
          bank_d       = ~bank_q;
          count_d      = wp_q;
          fresh_d      = 1'b0;
          res_d.status = STAT_OK;
          state_d      = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  `ASSERT_CLK(a_count_range, clk_i, rst_ni,
    count_q >= CW'(1) && 32'(count_q) <= 32'(MAX_SPLITS), "split count out of range")
  `ASSERT_CLK(a_fresh_single, clk_i, rst_ni, fresh_q |-> count_q == CW'(1),
    "initial table holds more than one point")
  `ASSERT_CLK(a_result_source, clk_i, rst_ni,
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH), "result word without finish")
  `ASSERT_CLK(a_busy_no_write, clk_i, rst_ni,
    (state_q == ST_IDLE || state_q == ST_CHECK) |-> !we, "table write outside a split")

endmodule

// File: bench/tagged_interval_map_checker.sv
// Checker for the tagged interval map: watches the cfg, in and out channels,
// keeps its own split table and compares every result word with its prediction.
// Depends on tim_pkg for the word types and codes.
`timescale 1ns / 100ps

module tagged_interval_map_checker
  import tim_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  tim_in_t          in_word_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  tim_out_t         out_word_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [AddrW-1:0] cfg_data_i,
  output int               mismatches_o,
  output int               pending_o
);

  localparam int Depth = MaxSplitsDef;

  // Shadow configuration and split table.
  logic [AddrW-1:0] lo_addr, hi_addr;
  logic [TagW-1:0]  init_tag;
  logic [AddrW-1:0] point_key [Depth];
  logic [TagW-1:0]  point_tag [Depth];
  int               point_cnt;
  tim_out_t         expected_results [$];

  // Put the table back to the single initial point.
  function automatic void clear_table();
    for (int i = 0; i < Depth; i++) begin
      point_key[i] = '0;
      point_tag[i] = '0;
    end
    point_key[0] = lo_addr;
    point_tag[0] = init_tag;
    point_cnt = 1;
  endfunction

  // Index of the last point at or below an address, point zero if none.
  function automatic int point_holding(logic [AddrW-1:0] a);
    int found;
    found = 0;
    for (int i = 0; i < point_cnt; i++)
      if (point_key[i] <= a) found = i;
    return found;
  endfunction

  function automatic logic [AddrW-1:0] end_of_region(int i);
    return (i + 1 < point_cnt) ? point_key[i + 1] : hi_addr;
  endfunction

  // Retag [start, start+len) and return the status of the split.
  function automatic logic [2:0] apply_split(logic [AddrW-1:0] start,
                                             logic [AddrW-1:0] len,
                                             logic [TagW-1:0] tag);
    logic [AddrW:0]   end65;
    logic [AddrW-1:0] stop;
    logic [TagW-1:0]  end_tag;
    logic             add_end;
    int               kept, n;
    logic [AddrW-1:0] nk [Depth];
    logic [TagW-1:0]  nt [Depth];
    if (len == 0)
      return (start < lo_addr || start >= hi_addr) ? STAT_RANGE : STAT_OK;
    end65 = {1'b0, start} + {1'b0, len};
    stop  = end65[AddrW-1:0];
    if (start < lo_addr || start >= hi_addr || end65[AddrW] || stop > hi_addr)
      return STAT_RANGE;
    end_tag = point_tag[point_holding(stop)];
    add_end = stop < hi_addr;
    kept = 0;
    for (int i = 0; i < point_cnt; i++)
      if (point_key[i] < start || point_key[i] > stop) kept++;
    if (kept + 1 + (add_end ? 1 : 0) > Depth) return STAT_FULL;
    for (int i = 0; i < Depth; i++) begin
      nk[i] = '0;
      nt[i] = '0;
    end
    n = 0;
    for (int i = 0; i < point_cnt; i++)
      if (point_key[i] < start) begin
        nk[n] = point_key[i];
        nt[n] = point_tag[i];
        n++;
      end
    nk[n] = start;
    nt[n] = tag;
    n++;
    if (add_end) begin
      nk[n] = stop;
      nt[n] = end_tag;
      n++;
    end
    for (int i = 0; i < point_cnt; i++)
      if (point_key[i] > stop) begin
        nk[n] = point_key[i];
        nt[n] = point_tag[i];
        n++;
      end
    point_key = nk;
    point_tag = nt;
    point_cnt = n;
    return STAT_OK;
  endfunction

  // Expected result word for one command, updating the table on a split.
  function automatic tim_out_t predict_result(tim_in_t w);
    tim_out_t r;
    int       seen, i;
    r = '0;
    case (w.cmd)
      CMD_SPLIT: begin
        r.status = apply_split(w.addr, w.length, w.tag_in);
      end
      CMD_GET: begin
        if (w.addr < lo_addr || w.addr >= hi_addr) begin
          r.status = STAT_RANGE;
        end else begin
          i = point_holding(w.addr);
          r.range_start = point_key[i];
          r.range_end   = end_of_region(i);
          r.tag_out     = point_tag[i];
        end
      end
      CMD_REGION: begin
        if (int'(w.iterate_index) >= Depth) begin
          r.status = STAT_IDX_BIG;
        end else begin
          seen = 0;
          r.status = STAT_ABSENT;
          for (i = 0; i < point_cnt; i++) begin
            if (point_tag[i] == w.tag_in) begin
              if (seen == int'(w.iterate_index)) begin
                r.status      = STAT_OK;
                r.range_start = point_key[i];
                r.range_end   = end_of_region(i);
                r.tag_out     = w.tag_in;
                r.next_index  = {1'b0, w.iterate_index} + 7'd1;
                break;
              end
              seen++;
            end
          end
          if (r.status != STAT_OK && seen > 0) r.status = STAT_NO_MORE;
        end
      end
      default: begin
        r.status = STAT_RANGE;
      end
    endcase
    return r;
  endfunction

  // Follow the three channels; compare before predicting so queue order holds.
  always @(posedge clk_i or negedge rst_ni) begin
    tim_out_t want;
    if (!rst_ni) begin
      lo_addr = '0;
      hi_addr = '1;
      init_tag = '0;
      clear_table();
      expected_results.delete();
      mismatches_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RANGE_MIN:   lo_addr = cfg_data_i;
          CFG_RANGE_MAX:   hi_addr = cfg_data_i;
          CFG_INITIAL_TAG: init_tag = cfg_data_i[TagW-1:0];
          default: ;
        endcase
        if (cfg_idx_i == CFG_RANGE_MIN || cfg_idx_i == CFG_RANGE_MAX ||
            cfg_idx_i == CFG_INITIAL_TAG) clear_table();
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          if (mismatches_o < 10)
            $display("%0t: result word with none expected: %p", $realtime, out_word_i);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.status !== out_word_i.status ||
              want.range_start !== out_word_i.range_start ||
              want.range_end !== out_word_i.range_end ||
              want.tag_out !== out_word_i.tag_out ||
              want.next_index !== out_word_i.next_index) begin
            if (mismatches_o < 10)
              $display("%0t: mismatch expected %p actual %p", $realtime, want, out_word_i);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_results.push_back(predict_result(in_word_i));
      pending_o <= expected_results.size();
    end
  end

endmodule

// File: bench/tagged_interval_map_core_tb.sv
// Testbench top for tagged_interval_map_core: clock, reset, command stimulus,
// receiver stalls, configuration phases, watchdog and final verdict.
// Depends on tim_pkg, tagged_interval_map_core and tagged_interval_map_checker.
`timescale 1ns / 100ps

module tagged_interval_map_core_tb;
  import tim_pkg::*;

  localparam int IdleLimit = 6000;
  localparam int DrainWait = 400;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  tim_in_t          in_word_i;
  logic             out_valid_o;
  logic             out_stall_i;
  tim_out_t         out_word_o;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [AddrW-1:0] cfg_data_i;
  int               mismatches;
  int               pending;

  // Stimulus controls; no_gaps and hold_request are shared with the receiver process.
  logic             no_gaps;
  logic             hold_request;
  logic [AddrW-1:0] cur_lo, cur_hi;

  tagged_interval_map_core dut (.*);

  tagged_interval_map_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_word_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_word_i(out_word_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .mismatches_o(mismatches), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (no_gaps || r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [AddrW-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Offer one word and hold it until taken, then maybe leave a gap.
  task automatic send_word(tim_in_t w);
    int g;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic send_cmd(logic [1:0] cmd, logic [AddrW-1:0] a, logic [AddrW-1:0] len,
                          logic [TagW-1:0] tag, logic [IdxW-1:0] idx);
    tim_in_t w;
    w.cmd = cmd;
    w.addr = a;
    w.length = len;
    w.tag_in = tag;
    w.iterate_index = idx;
    send_word(w);
  endtask

  // Let every outstanding word drain, then rewrite all three registers.
  task automatic configure(logic [AddrW-1:0] lo, logic [AddrW-1:0] hi,
                           logic [TagW-1:0] tag);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_RANGE_MIN;
    cfg_data_i <= lo;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_RANGE_MAX;
    cfg_data_i <= hi;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_INITIAL_TAG;
    cfg_data_i <= AddrW'(tag);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
  endtask

  // Random commands, mostly inside a small window above the range start.
  task automatic random_cmds(int count);
    logic [AddrW-1:0] win, a, len;
    logic [1:0]       cmd;
    int               r;
    win = (cur_hi > cur_lo) ? cur_hi - cur_lo : 64'd4096;
    if (win > 64'd4096) win = 64'd4096;
    for (int k = 0; k < count; k++) begin
      no_gaps = (k % 60) >= 45;
      r = $urandom_range(0, 99);
      cmd = (r < 45) ? CMD_SPLIT : (r < 75) ? CMD_GET : (r < 95) ? CMD_REGION : 2'd3;
      a = ($urandom_range(0, 99) < 85) ? cur_lo + rand64() % win : rand64();
      r = $urandom_range(0, 99);
      if (r < 75) len = AddrW'($urandom_range(1, 64));
      else if (r < 82) len = '0;
      else if (r < 90) len = cur_hi - a;
      else len = rand64();
      send_cmd(cmd, a, len, 3'($urandom()),
               ($urandom_range(0, 3) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 4)));
    end
    no_gaps = 1'b0;
  endtask

  // Receiver: random stalls plus one long hold-off when requested.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (800) @(posedge clk_i);
        hold_request = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= (!no_gaps && $urandom_range(0, 99) < 25) ||
                       ($urandom_range(0, 199) == 0);
      end
    end
  end

  // Watchdog on cycles without any accepted word or register write.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        idle = 0;
      else
        idle++;
      if (idle >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_word_i    = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_RANGE_MIN;
    cfg_data_i   = '0;
    no_gaps      = 1'b0;
    hold_request = 1'b0;
    cur_lo       = '0;
    cur_hi       = '1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at reset defaults.
    send_cmd(CMD_GET, '0, '0, '0, '0);
    send_cmd(CMD_GET, '1, '0, '0, '0);
    send_cmd(CMD_SPLIT, 64'h100, '0, 3'd7, '0);
    send_cmd(CMD_SPLIT, 64'h100, 64'h40, 3'd7, '0);
    send_cmd(CMD_SPLIT, 64'h120, 64'h10, 3'd3, '0);
    send_cmd(CMD_GET, 64'h128, '0, '0, '0);
    send_cmd(CMD_GET, 64'h130, '0, '0, '0);
    send_cmd(CMD_REGION, '0, '0, 3'd7, 6'd0);
    send_cmd(CMD_REGION, '0, '0, 3'd7, 6'd1);
    send_cmd(CMD_REGION, '0, '0, 3'd7, 6'd2);
    send_cmd(CMD_REGION, '0, '0, 3'd5, 6'd63);
    send_cmd(CMD_REGION, '0, '0, 3'd0, 6'd63);
    send_cmd(CMD_SPLIT, 64'h5, '1, 3'd1, '0);
    send_cmd(CMD_SPLIT, '1, 64'd1, 3'd2, '0);
    send_cmd(CMD_SPLIT, 64'hFFFF_FFFF_FFFF_FFFE, 64'd1, 3'd4, '0);
    send_cmd(CMD_GET, 64'hFFFF_FFFF_FFFF_FFFE, '0, '0, '0);
    send_cmd(2'd3, '1, '1, '1, '1);
    send_cmd(CMD_SPLIT, '0, '1, 3'd6, '0);
    send_cmd(CMD_GET, 64'h8000_0000_0000_0000, '0, '0, '0);
    send_cmd(CMD_REGION, '0, '0, 3'd6, 6'd0);
    random_cmds(80);

    // Narrow range, with a long receiver hold-off in the middle.
    configure(64'h1000, 64'h2000, 3'd5);
    send_cmd(CMD_SPLIT, 64'h0FFF, 64'd4, 3'd1, '0);
    send_cmd(CMD_SPLIT, 64'h1FF0, 64'h10, 3'd1, '0);
    send_cmd(CMD_SPLIT, 64'h1FF0, 64'h11, 3'd1, '0);
    random_cmds(40);
    hold_request = 1'b1;
    random_cmds(50);

    // Range at the top of the address space.
    configure(64'hFFFF_FFFF_FFFF_F000, '1, 3'd7);
    random_cmds(80);

    // Tiny range that fills the table quickly.
    configure('0, 64'h80, 3'd3);
    random_cmds(110);

    // Empty ranges: equal bounds, then inverted extremes.
    configure(64'h40, 64'h40, 3'd1);
    random_cmds(20);
    send_cmd(CMD_REGION, '0, '0, 3'd1, 6'd0);
    configure('1, '0, 3'd0);
    random_cmds(20);
    send_cmd(CMD_REGION, '0, '0, 3'd0, 6'd0);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
